// ----- design/tcbbm_pkg.sv -----
// Shared types and constants for the two-cell bridge balancing modulator.
package tcbbm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int ERR_W     = 32;
    localparam int DUTY_W    = 16;
    localparam int DUTY_FRAC = 14;
    localparam int CLAMP_W   = 48;
    localparam int CNT_W     = $clog2(DUTY_W);
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd41;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd4096;

    localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sh7FFF;
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = 16'sh8000;

    // register index, taken from paddr[2]
    localparam logic REG_PROP_GAIN  = 1'b0;
    localparam logic REG_INTEG_GAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_SAT,
        ST_MUL_PROP,
        ST_MUL_INTEG,
        ST_SUM,
        ST_SHARE,
        ST_DIV_LOAD,
        ST_DIV_CHECK,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MUL_ERR,
        MUL_PROP,
        MUL_INTEG
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     ld_y2;
        logic     ld_err;
        logic     ld_avg;
        logic     ld_acc;
        logic     ld_sum;
        logic     ld_share;
        logic     div_load;
        logic     div_check;
        logic     div_step;
        logic     div_end;
        logic     out_load;
    } t_ctrl;

endpackage

// ----- design/two_cell_bridge_balancing_modulator_core.sv -----
// Two-cell bridge balancing modulator: share split, balancing PI and duty division.
//
// One control item enters on the slave stream, one result leaves on the master stream.
// The block is busy while an item is worked: a shared signed multiplier forms the
// balancing error and both gain products in three passes, and a shared restoring
// divider then produces the lower and upper duties one quotient bit per cycle.
// A division takes 16 steps and runs once for each duty; it is skipped for a duty whose
// target is zero or whose quotient would overflow, and that duty then saturates.
// A finished result sits in an output register, so the block only stalls at the end
// of an item when the previous result is still untaken.
// Gains are written through the APB-style port; the user must write them only while no
// item is in flight, as the block itself does not enforce it.
module two_cell_bridge_balancing_modulator_core #(
    parameter int SAMPLE_WIDTH = tcbbm_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = tcbbm_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // stream in
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // bridge_ref, cap_one_volt, cap_two_volt, cap_one_target, cap_two_target,
    // bridge_current (lowest first), zero padded to bytes
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // stream out
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // duty_lower, duty_upper (lowest first)
    output logic [2*tcbbm_pkg::DUTY_W-1:0]           m_axis_tdata,
    // target_zero
    output logic                                     m_axis_tuser,
    // configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [tcbbm_pkg::CFG_AW-1:0]             paddr,
    input  logic [tcbbm_pkg::CFG_DW-1:0]             pwdata,
    output logic [tcbbm_pkg::CFG_DW-1:0]             prdata,
    output logic                                     pready
);
    import tcbbm_pkg::*;

    localparam int W         = SAMPLE_WIDTH;
    localparam int D_W       = W + 2;
    localparam int MA_W      = (D_W > GAIN_W + 1) ? D_W : GAIN_W + 1;
    localparam int P_W       = MA_W + ERR_W;
    localparam int Y_TERM_W  = W + GAIN_FRAC + 1 + FRAC_BITS;
    localparam int G_TERM_W  = GAIN_W + 1 + ERR_W;
    localparam int ACC_W     = ((Y_TERM_W > G_TERM_W) ? Y_TERM_W : G_TERM_W) + 2;
    localparam int Y_SHIFT   = GAIN_FRAC - 1 + FRAC_BITS;
    localparam int ACC_SHIFT = GAIN_FRAC + FRAC_BITS;
    localparam int SH_W      = ACC_W - ACC_SHIFT + 2;
    localparam int MAG_W     = (SH_W > CLAMP_W) ? SH_W : CLAMP_W;
    localparam int N_W       = CLAMP_W + DUTY_FRAC;
    localparam int DSH_W     = W + DUTY_W - 1;

    localparam logic [MAG_W-1:0] SHARE_LIMIT = MAG_W'(1) << (CLAMP_W - 1);

    // control state
    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic              r_m_valid;
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic signed [ERR_W-1:0] r_prev;

    // payload
    logic signed [W-1:0]     r_v, r_c1, r_c2, r_t1, r_t2, r_cur;
    logic signed [D_W-1:0]   r_y2;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ERR_W-1:0] r_err, r_avg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SH_W-1:0]  r_up, r_low;
    logic                    r_sel, r_zero, r_tzero, r_ovf, r_neg, r_share_neg;
    logic [N_W-1:0]          r_rem;
    logic [W-1:0]            r_dmag;
    logic [DSH_W-1:0]        r_dsh;
    logic [DUTY_W-1:0]       r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [DUTY_W-1:0] r_duty_lo, r_duty_up;
    logic [2*DUTY_W-1:0]     r_m_data;
    logic                    r_m_user;

    // combinational datapath
    logic signed [D_W-1:0]   w_v, w_c1, w_c2, w_diff, w_y2;
    logic signed [MA_W-1:0]  w_mul_a;
    logic signed [ERR_W-1:0] w_mul_b;
    logic signed [P_W-1:0]   w_prod;
    logic [P_W-ERR_W:0]      w_hi;
    logic signed [ERR_W-1:0] w_err_sat;
    logic signed [ERR_W:0]   w_avg_sum;
    logic signed [SH_W-1:0]  w_up, w_share;
    logic signed [W-1:0]     w_target;
    logic [SH_W-1:0]         w_share_mag;
    logic [MAG_W-1:0]        w_mag_ext;
    logic [CLAMP_W-1:0]      w_mag_clamp;
    logic                    w_ovf, w_fit;
    logic signed [DUTY_W-1:0] w_duty;
    logic                    w_cfg_wr;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_PROP_GAIN:  prdata = CFG_DW'(r_prop_gain);
            REG_INTEG_GAIN: prdata = CFG_DW'(r_integ_gain);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (s_axis_tvalid) n_state = ST_MUL_ERR;
            ST_MUL_ERR:   n_state = ST_SAT;
            ST_SAT:       n_state = ST_MUL_PROP;
            ST_MUL_PROP:  n_state = ST_MUL_INTEG;
            ST_MUL_INTEG: n_state = ST_SUM;
            ST_SUM:       n_state = ST_SHARE;
            ST_SHARE:     n_state = ST_DIV_LOAD;
            ST_DIV_LOAD:  n_state = ST_DIV_CHECK;
            ST_DIV_CHECK: n_state = (r_tzero || w_ovf) ? ST_DIV_END : ST_DIV_STEP;
            ST_DIV_STEP:  if (r_cnt == '0) n_state = ST_DIV_END;
            ST_DIV_END:   n_state = r_sel ? ST_FINISH : ST_DIV_LOAD;
            ST_FINISH:    if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = MUL_ERR;
        unique case (r_state)
            ST_IDLE:      ctrl.in_ready = 1'b1;
            ST_MUL_ERR: begin
                ctrl.mul_en = 1'b1;
                ctrl.ld_y2  = 1'b1;
            end
            ST_SAT:       ctrl.ld_err = 1'b1;
            ST_MUL_PROP: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_PROP;
                ctrl.ld_avg  = 1'b1;
            end
            ST_MUL_INTEG: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_INTEG;
                ctrl.ld_acc  = 1'b1;
            end
            ST_SUM:       ctrl.ld_sum    = 1'b1;
            ST_SHARE:     ctrl.ld_share  = 1'b1;
            ST_DIV_LOAD:  ctrl.div_load  = 1'b1;
            ST_DIV_CHECK: ctrl.div_check = 1'b1;
            ST_DIV_STEP:  ctrl.div_step  = 1'b1;
            ST_DIV_END:   ctrl.div_end   = 1'b1;
            ST_FINISH:    ctrl.out_load  = !r_m_valid || m_axis_tready;
            default:      ctrl = '0;
        endcase
    end

    assign s_axis_tready = ctrl.in_ready;

    // ---------------- datapath logic ----------------
    always_comb begin
        w_v  = D_W'(r_v);
        w_c1 = D_W'(r_c1);
        w_c2 = D_W'(r_c2);
        // equilibrium share, doubled
        if (w_v > (w_c2 <<< 1))
            w_y2 = (w_v - w_c2) <<< 1;
        else if (w_v > (w_c1 <<< 1))
            w_y2 = w_c1 <<< 1;
        else if (w_v < -(w_c2 <<< 1))
            w_y2 = (w_v + w_c2) <<< 1;
        else if (w_v < -(w_c1 <<< 1))
            w_y2 = -(w_c1 <<< 1);
        else
            w_y2 = w_v;
        w_diff = (D_W'(r_t1) - w_c1) - (D_W'(r_t2) - w_c2);
    end

    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_ERR: begin
                w_mul_a = MA_W'(w_diff);
                w_mul_b = ERR_W'(r_cur);
            end
            MUL_PROP: begin
                w_mul_a = MA_W'(signed'({1'b0, r_prop_gain}));
                w_mul_b = r_err;
            end
            MUL_INTEG: begin
                w_mul_a = MA_W'(signed'({1'b0, r_integ_gain}));
                w_mul_b = r_avg;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // saturate the error product to 32 bits
    always_comb begin
        w_hi = r_prod[P_W-1:ERR_W-1];
        if (!r_prod[P_W-1] && (|w_hi))
            w_err_sat = {1'b0, {(ERR_W-1){1'b1}}};
        else if (r_prod[P_W-1] && !(&w_hi))
            w_err_sat = {1'b1, {(ERR_W-1){1'b0}}};
        else
            w_err_sat = r_prod[ERR_W-1:0];
    end

    assign w_avg_sum = (ERR_W+1)'(r_err) + (ERR_W+1)'(r_prev);
    assign w_up      = SH_W'(r_acc >>> ACC_SHIFT);

    // divider operand pick and magnitude
    always_comb begin
        w_share     = r_sel ? r_up : r_low;
        w_target    = r_sel ? r_t1 : r_t2;
        w_share_mag = w_share[SH_W-1] ? SH_W'(-w_share) : SH_W'(w_share);
        w_mag_ext   = MAG_W'(w_share_mag);
        w_mag_clamp = (w_mag_ext > SHARE_LIMIT) ? SHARE_LIMIT[CLAMP_W-1:0]
                                                : w_mag_ext[CLAMP_W-1:0];
    end

    assign w_ovf = r_rem >= N_W'({r_dmag, {DUTY_W{1'b0}}});
    assign w_fit = r_rem >= N_W'(r_dsh);

    always_comb begin
        if (r_tzero)
            w_duty = r_share_neg ? DUTY_MIN : DUTY_MAX;
        else if (r_ovf || r_quo[DUTY_W-1])
            w_duty = r_neg ? DUTY_MIN : DUTY_MAX;
        else if (r_neg)
            w_duty = -signed'(r_quo);
        else
            w_duty = signed'(r_quo);
    end

    // ---------------- registers with reset ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_m_valid    <= 1'b0;
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_prev       <= '0;
        end else begin
            r_state <= n_state;
            if (ctrl.out_load)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_PROP_GAIN)
                    r_prop_gain <= pwdata[GAIN_W-1:0];
                else
                    r_integ_gain <= pwdata[GAIN_W-1:0];
            end
            // previous error is consumed by the average in the same cycle
            if (ctrl.ld_avg)
                r_prev <= r_err;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_v   <= s_axis_tdata[0*W +: W];
            r_c1  <= s_axis_tdata[1*W +: W];
            r_c2  <= s_axis_tdata[2*W +: W];
            r_t1  <= s_axis_tdata[3*W +: W];
            r_t2  <= s_axis_tdata[4*W +: W];
            r_cur <= s_axis_tdata[5*W +: W];
        end
        if (ctrl.mul_en)
            r_prod <= w_prod;
        if (ctrl.ld_y2)
            r_y2 <= w_y2;
        if (ctrl.ld_err)
            r_err <= w_err_sat;
        if (ctrl.ld_avg)
            r_avg <= w_avg_sum[ERR_W:1];
        if (ctrl.ld_acc)
            r_acc <= (ACC_W'(r_y2) <<< Y_SHIFT) + ACC_W'(r_prod);
        if (ctrl.ld_sum)
            r_acc <= r_acc + ACC_W'(r_prod);
        if (ctrl.ld_share) begin
            r_up   <= w_up;
            r_low  <= SH_W'(r_v) - w_up;
            r_sel  <= 1'b0;
            r_zero <= 1'b0;
        end
        if (ctrl.div_load) begin
            r_rem       <= {w_mag_clamp, {DUTY_FRAC{1'b0}}};
            r_dmag      <= w_target[W-1] ? W'(-w_target) : W'(w_target);
            r_tzero     <= (w_target == '0);
            r_share_neg <= w_share[SH_W-1];
            r_neg       <= w_share[SH_W-1] ^ w_target[W-1];
        end
        if (ctrl.div_check) begin
            r_ovf <= w_ovf;
            r_dsh <= {r_dmag, {(DUTY_W-1){1'b0}}};
            r_cnt <= CNT_W'(DUTY_W - 1);
            r_quo <= '0;
        end
        if (ctrl.div_step) begin
            // one restoring step per cycle, divisor walks right
            if (w_fit)
                r_rem <= r_rem - N_W'(r_dsh);
            r_quo <= {r_quo[DUTY_W-2:0], w_fit};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (ctrl.div_end) begin
            if (r_sel)
                r_duty_up <= w_duty;
            else
                r_duty_lo <= w_duty;
            r_zero <= r_zero | r_tzero;
            r_sel  <= 1'b1;
        end
        if (ctrl.out_load) begin
            r_m_data <= {r_duty_up, r_duty_lo};
            r_m_user <= r_zero;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef ASSERT_OFF
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_FINISH))
        else $error("result raised outside the finish step");

    a_div_only_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_STEP) |-> (!r_tzero && !r_ovf))
        else $error("division running on zero target or saturated quotient");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_STEP) |-> (r_rem < N_W'({r_dsh, 1'b0})))
        else $error("divider remainder out of bound");
`endif

endmodule
